/* rtl/otb_pkg.sv */
// ----------------------------------------------------------------------------
// otb_pkg
// Shared constants and codes for the Otsu threshold binarizer.
// ----------------------------------------------------------------------------
package otb_pkg;

	localparam int COUNT_WIDTH_DEF = 24;
	localparam int GRAY_LEVELS     = 256;
	localparam int PIX_W           = 8;

	// last candidate threshold of the scan
	localparam logic [PIX_W-1:0] SCAN_LAST = 8'd254;
	localparam logic [PIX_W-1:0] THR_INIT  = 8'd1;
	localparam logic [PIX_W-1:0] PIX_ON    = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_OFF   = 8'h00;

	localparam logic ACT_ACCUM    = 1'b0;
	localparam logic ACT_BINARIZE = 1'b1;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	localparam logic [16:0] WEIGHT_ONE = 17'h10000;

endpackage

/* rtl/otsu_threshold_binarizer.sv */
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer
// Histogram build, Otsu threshold scan and pixel binarization.
// ----------------------------------------------------------------------------
// binarize: result in the next cycle, one pixel every cycle while not busy
// accumulate: one pixel per cycle unless busy; histogram memory read-modify-write
// frame end: busy for the scan; each candidate is read, and where both classes
//   hold pixels, six products run on one 8-bit digit multiplier digit by digit up
//   to the top nonzero one; then four divisions (skipped for an empty divisor)
// reset clears histogram valid bits and totals at once; internal threshold is 1
module otsu_threshold_binarizer #(
	parameter int COUNT_WIDTH = otb_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [7:0]  pixel,
	input  logic        last,
	output logic        strobe,
	output logic        kind,
	output logic [7:0]  binary_pixel,
	output logic [7:0]  threshold,
	output logic [15:0] global_mean,
	output logic [15:0] low_class_mean,
	output logic [15:0] high_class_mean,
	output logic [16:0] low_class_weight,
	output logic [16:0] high_class_weight
);
	import otb_pkg::*;

	localparam int CW   = COUNT_WIDTH;
	localparam int SW   = CW + 8;
	localparam int DW   = 2 * CW + 8;
	localparam int NUMW = 4 * CW + 16;
	localparam int DENW = 2 * CW;
	localparam int PW   = 6 * CW + 16;
	localparam int QW   = CW + 17;
	localparam int DCW  = $clog2(QW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_FLUSH, S_SCAN_RD, S_SCAN_ACC, S_MLOAD, S_MUL, S_DLOAD, S_DIV, S_EMIT
	} state_t;
	typedef enum logic [2:0] {M_P1, M_P2, M_SQ, M_DEN, M_LHS, M_RHS} mstep_t;
	typedef enum logic [1:0] {D_GM, D_LM, D_HM, D_W1} dstep_t;

	state_t state_q;
	mstep_t mstep_q;
	dstep_t dstep_q;

	logic accept;
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// histogram memory and valid bits
	logic [CW-1:0]          hist_mem [GRAY_LEVELS];
	logic [GRAY_LEVELS-1:0] vld_q;
	logic [PIX_W-1:0]       rd_addr;
	logic [CW-1:0]          rd_q;
	logic                   rdv_q;

	// accumulate stage
	logic             acc_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             wr_fwd_q;
	logic [PIX_W-1:0] wr_pix_q;
	logic [CW-1:0]    wr_data_q;
	logic [CW-1:0]    cnt_cur, cnt_new;
	logic             wr_en, clear;
	logic [CW-1:0]    ptot_q;
	logic [SW-1:0]    itot_q;

	// scan datapath
	logic [PIX_W-1:0] t_q, thr_q, cur_thr_q;
	logic [CW-1:0]    n1_q, best_n1_q, cbin, n1_new;
	logic [SW-1:0]    s1_q, best_s1_q, s1_new, tprod;
	logic [DW-1:0]    p1_q, d_q, p2;
	logic [NUMW-1:0]  num_q, best_num_q;
	logic [DENW-1:0]  den_q, best_den_q;
	logic [PW-1:0]    lhs_q, ma_q, macc_q, op_a;
	logic [DW-1:0]    mb_q, op_b;

	// divider
	logic [QW-1:0]  dn_q, dnum;
	logic [CW-1:0]  dd_q, dden, dr_q, hcnt;
	logic [SW-1:0]  hsum;
	logic [DCW-1:0] dcnt_q;
	logic [CW:0]    rem_sh, rem_nx;
	logic           rem_ge;
	logic [15:0]    gm_q, lm_q, hm_q;
	logic [16:0]    w1_q;

	// registered results
	logic        strobe_q, kind_q;
	logic [7:0]  bp_q, thr_out_q;
	logic [15:0] gm_out_q, lm_out_q, hm_out_q;
	logic [16:0] lw_out_q, hw_out_q;

	assign strobe            = strobe_q;
	assign kind              = kind_q;
	assign binary_pixel      = bp_q;
	assign threshold         = thr_out_q;
	assign global_mean       = gm_out_q;
	assign low_class_mean    = lm_out_q;
	assign high_class_mean   = hm_out_q;
	assign low_class_weight  = lw_out_q;
	assign high_class_weight = hw_out_q;

	// ---------------- memory ----------------
	assign rd_addr = (state_q == S_SCAN_RD) ? t_q : pixel;

	always_ff @(posedge clk) begin
		rd_q  <= hist_mem[rd_addr];
		rdv_q <= vld_q[rd_addr];
		if (wr_en) begin
			hist_mem[pix_s1] <= cnt_new;
		end
	end

	// ---------------- accumulate ----------------
	// the write of the previous pixel lands on the edge that reads this one
	assign cnt_cur = (wr_fwd_q && (wr_pix_q == pix_s1)) ? wr_data_q :
	                 (rdv_q ? rd_q : '0);
	assign cnt_new = cnt_cur + 1'b1;
	assign wr_en   = acc_s1 && (ptot_q != {CW{1'b1}});
	assign clear   = (state_q == S_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1   <= 1'b0;
			wr_fwd_q <= 1'b0;
			vld_q    <= '0;
			ptot_q   <= '0;
			itot_q   <= '0;
		end else begin
			acc_s1   <= accept && (action == ACT_ACCUM);
			wr_fwd_q <= wr_en;
			if (clear) begin
				vld_q  <= '0;
				ptot_q <= '0;
				itot_q <= '0;
			end else if (wr_en) begin
				vld_q[pix_s1] <= 1'b1;
				ptot_q        <= ptot_q + 1'b1;
				itot_q        <= itot_q + SW'(pix_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		pix_s1    <= pixel;
		wr_pix_q  <= pix_s1;
		wr_data_q <= cnt_new;
	end

	// ---------------- scan arithmetic ----------------
	assign cbin   = rdv_q ? rd_q : '0;
	assign n1_new = n1_q + cbin;
	assign tprod  = SW'(t_q) * SW'(cbin);
	assign s1_new = s1_q + tprod;
	assign p2     = macc_q[DW-1:0];

	always_comb begin
		case (mstep_q)
			M_P1: begin
				op_a = PW'(s1_q);
				op_b = DW'(ptot_q);
			end
			M_P2: begin
				op_a = PW'(itot_q);
				op_b = DW'(n1_q);
			end
			M_SQ: begin
				op_a = PW'(d_q);
				op_b = d_q;
			end
			M_DEN: begin
				op_a = PW'(n1_q);
				op_b = DW'(ptot_q - n1_q);
			end
			M_LHS: begin
				op_a = PW'(num_q);
				op_b = DW'(best_den_q);
			end
			M_RHS: begin
				op_a = PW'(best_num_q);
				op_b = DW'(den_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// rounded quotients: (num + den/2) / den
	assign hsum = itot_q - best_s1_q;
	assign hcnt = ptot_q - best_n1_q;

	always_comb begin
		case (dstep_q)
			D_GM: begin
				dnum = QW'({itot_q, 8'h00}) + QW'(ptot_q >> 1);
				dden = ptot_q;
			end
			D_LM: begin
				dnum = QW'({best_s1_q, 8'h00}) + QW'(best_n1_q >> 1);
				dden = best_n1_q;
			end
			D_HM: begin
				dnum = QW'({hsum, 8'h00}) + QW'(hcnt >> 1);
				dden = hcnt;
			end
			D_W1: begin
				dnum = QW'({best_n1_q, 16'h0000}) + QW'(ptot_q >> 1);
				dden = ptot_q;
			end
			default: begin
				dnum = '0;
				dden = '0;
			end
		endcase
	end

	assign rem_sh = {dr_q, dn_q[QW-1]};
	assign rem_ge = (rem_sh >= {1'b0, dd_q});
	assign rem_nx = rem_ge ? (rem_sh - {1'b0, dd_q}) : rem_sh;

	always_ff @(posedge clk) begin
		case (state_q)
			S_FLUSH: begin
				t_q        <= '0;
				thr_q      <= THR_INIT;
				best_num_q <= '0;
				best_den_q <= DENW'(1);
			end
			S_SCAN_ACC: begin
				if (t_q == '0) begin
					n1_q <= cbin;
					s1_q <= '0;
					t_q  <= t_q + 1'b1;
				end else begin
					n1_q <= n1_new;
					s1_q <= s1_new;
					if (t_q == THR_INIT) begin
						best_n1_q <= n1_new;
						best_s1_q <= s1_new;
					end
					if (n1_new == '0) begin
						t_q <= t_q + 1'b1;
					end
				end
			end
			S_MLOAD: begin
				ma_q   <= op_a;
				mb_q   <= op_b;
				macc_q <= '0;
			end
			S_MUL: begin
				if (mb_q != '0) begin
					macc_q <= macc_q + ma_q * PW'(mb_q[7:0]);
					ma_q   <= ma_q << 8;
					mb_q   <= mb_q >> 8;
				end else begin
					case (mstep_q)
						M_P1:  p1_q  <= macc_q[DW-1:0];
						M_P2:  d_q   <= (p1_q >= p2) ? (p1_q - p2) : (p2 - p1_q);
						M_SQ:  num_q <= macc_q[NUMW-1:0];
						M_DEN: den_q <= macc_q[DENW-1:0];
						M_LHS: lhs_q <= macc_q;
						M_RHS: begin
							// first strict maximum wins
							if (lhs_q > macc_q) begin
								best_num_q <= num_q;
								best_den_q <= den_q;
								best_n1_q  <= n1_q;
								best_s1_q  <= s1_q;
								thr_q      <= t_q;
							end
							t_q <= t_q + 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_DLOAD: begin
				dn_q   <= dnum;
				dd_q   <= dden;
				dr_q   <= '0;
				dcnt_q <= DCW'(QW);
				if (dden == '0) begin
					case (dstep_q)
						D_GM:    gm_q <= '0;
						D_LM:    lm_q <= '0;
						D_HM:    hm_q <= '0;
						default: w1_q <= '0;
					endcase
				end
			end
			S_DIV: begin
				if (dcnt_q != '0) begin
					dr_q   <= rem_nx[CW-1:0];
					dn_q   <= {dn_q[QW-2:0], rem_ge};
					dcnt_q <= dcnt_q - 1'b1;
				end else begin
					case (dstep_q)
						D_GM:    gm_q <= dn_q[15:0];
						D_LM:    lm_q <= dn_q[15:0];
						D_HM:    hm_q <= dn_q[15:0];
						default: w1_q <= dn_q[16:0];
					endcase
				end
			end
			default: ;
		endcase
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mstep_q   <= M_P1;
			dstep_q   <= D_GM;
			cur_thr_q <= THR_INIT;
			strobe_q  <= 1'b0;
			kind_q    <= KIND_REPORT;
			bp_q      <= PIX_OFF;
			thr_out_q <= '0;
			gm_out_q  <= '0;
			lm_out_q  <= '0;
			hm_out_q  <= '0;
			lw_out_q  <= '0;
			hw_out_q  <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (action == ACT_BINARIZE)) begin
						strobe_q  <= 1'b1;
						kind_q    <= KIND_PIXEL;
						bp_q      <= (pixel > cur_thr_q) ? PIX_ON : PIX_OFF;
						thr_out_q <= '0;
						gm_out_q  <= '0;
						lm_out_q  <= '0;
						hm_out_q  <= '0;
						lw_out_q  <= '0;
						hw_out_q  <= '0;
					end else if (accept && last) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH:   state_q <= S_SCAN_RD;
				S_SCAN_RD: state_q <= S_SCAN_ACC;
				S_SCAN_ACC: begin
					dstep_q <= D_GM;
					mstep_q <= M_P1;
					if (t_q == '0) begin
						state_q <= S_SCAN_RD;
					end else if (n1_new == ptot_q) begin
						state_q <= S_DLOAD;
					end else if (n1_new == '0) begin
						state_q <= (t_q == SCAN_LAST) ? S_DLOAD : S_SCAN_RD;
					end else begin
						state_q <= S_MLOAD;
					end
				end
				S_MLOAD: state_q <= S_MUL;
				S_MUL: begin
					if (mb_q == '0) begin
						if (mstep_q == M_RHS) begin
							state_q <= (t_q == SCAN_LAST) ? S_DLOAD : S_SCAN_RD;
						end else begin
							mstep_q <= mstep_t'(mstep_q + 1'b1);
							state_q <= S_MLOAD;
						end
					end
				end
				S_DLOAD: begin
					if (dden == '0) begin
						if (dstep_q == D_W1) begin
							state_q <= S_EMIT;
						end else begin
							dstep_q <= dstep_t'(dstep_q + 1'b1);
						end
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dcnt_q == '0) begin
						if (dstep_q == D_W1) begin
							state_q <= S_EMIT;
						end else begin
							dstep_q <= dstep_t'(dstep_q + 1'b1);
							state_q <= S_DLOAD;
						end
					end
				end
				S_EMIT: begin
					strobe_q  <= 1'b1;
					kind_q    <= KIND_REPORT;
					bp_q      <= PIX_OFF;
					thr_out_q <= thr_q;
					gm_out_q  <= gm_q;
					lm_out_q  <= lm_q;
					hm_out_q  <= hm_q;
					lw_out_q  <= w1_q;
					hw_out_q  <= (ptot_q == '0) ? '0 : (WEIGHT_ONE - w1_q);
					cur_thr_q <= thr_q;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/otb_checker.sv */
// ----------------------------------------------------------------------------
// otb_checker
// Port-level checks for the Otsu threshold binarizer.
// ----------------------------------------------------------------------------
module otb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       action,
	input logic       last,
	input logic       strobe,
	input logic       kind,
	input logic [7:0] binary_pixel,
	input logic [7:0] threshold
);
	import otb_pkg::*;

	// binarize transfer answers on the next cycle
	a_bin_resp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ACT_BINARIZE) |=> strobe && (kind == KIND_PIXEL))
		else $error("binarize transfer without pixel result");

	// plain accumulate gives no result
	a_acc_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ACT_ACCUM) && !last |=> !strobe)
		else $error("result after accumulate transfer");

	// frame end starts the search
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ACT_ACCUM) && last |=> busy)
		else $error("no search after last pixel");

	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_REPORT) |-> (threshold >= 8'd1) && (threshold <= SCAN_LAST))
		else $error("threshold out of range");

	a_bin_value: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_PIXEL) |-> (binary_pixel == PIX_ON) || (binary_pixel == PIX_OFF))
		else $error("binarized pixel not black or white");

endmodule

bind otsu_threshold_binarizer otb_checker u_otb_checker (.*);
